>>> hdl/path_option_payoff_defines.svh
// Assertion macros shared by the path payoff RTL.
`ifndef PATH_OPTION_PAYOFF_DEFINES_SVH
`define PATH_OPTION_PAYOFF_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion with an explicit clock and active-low reset.
`define POP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Clocked assertion on the block's own clock and reset.
`define POP_ASSERT(lbl, prop, msg) `POP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define POP_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define POP_ASSERT(lbl, prop, msg)
`endif

`endif

>>> hdl/pop_pkg.sv
// Package of types and constants for the path payoff block.
package pop_pkg;

  localparam int PriceW     = 32;
  localparam int DiscW      = 17;
  localparam int ModeW      = 2;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;
  localparam int MaxPathLen = 1024;

  typedef enum logic [ModeW-1:0] {
    PopCall     = 2'd0,
    PopLookback = 2'd1,
    PopBarrier  = 2'd2,
    PopCompound = 2'd3
  } pop_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPayoffMode     = 2'd0,
    RegStrikeLevel    = 2'd1,
    RegSecondLevel    = 2'd2,
    RegDiscountFactor = 2'd3
  } pop_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StLbMul,
    StLbSub,
    StDisc,
    StRound,
    StDivPrep,
    StDiv,
    StCmp
  } pop_state_e;

endpackage

>>> hdl/pop_intf.sv
// Handshake interfaces for the sample, result and configuration channels.
interface pop_smp_if;
  logic                         valid;
  logic                         ready;
  logic [pop_pkg::PriceW-1:0]   price_sample;
  logic                         last_sample;

  modport source (output valid, price_sample, last_sample, input ready);
  modport sink   (input valid, price_sample, last_sample, output ready);
endinterface

interface pop_res_if;
  logic                         valid;
  logic                         ready;
  logic [pop_pkg::PriceW-1:0]   payoff_value;
  logic                         barrier_crossed;

  modport source (output valid, payoff_value, barrier_crossed, input ready);
  modport sink   (input valid, payoff_value, barrier_crossed, output ready);
endinterface

interface pop_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pop_pkg::CfgIdxW-1:0]    index;
  logic [pop_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/path_option_payoff.sv
// Path payoff evaluator: one price sample per beat, payoff beat on the last sample.
//
// Each sample that does not end a path only updates the path state: the running
// minimum, the barrier flag, the excess sum and the sample count update as it
// is accepted. The sample that ends a path hands the path to a small
// sequencer around one shared 33 x 32 multiplier and a one-bit-per-cycle
// restoring divider, and the sample input is not ready until the result sits
// in the output register. Call and barrier modes go through StDisc and StRound,
// lookback through StLbMul and StLbSub first (two passes through the multiplier)
// and the compound mode through StDivPrep, StDiv and StCmp. A result waiting in
// the output register does not stop new samples. Configuration must be written
// with no path in progress; the block does not enforce this, and the cfg port is
// always ready.
`include "path_option_payoff_defines.svh"

module path_option_payoff #(
  parameter int MAX_PATH_LEN = pop_pkg::MaxPathLen
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pop_smp_if.sink   sample_i,
  pop_res_if.source result_o,
  pop_cfg_if.sink   cfg_i
);

  localparam int PriceW = pop_pkg::PriceW;
  localparam int DiscW  = pop_pkg::DiscW;
  localparam int CntW   = $clog2(MAX_PATH_LEN + 1);
  localparam int SumW   = PriceW + CntW;
  localparam int NumW   = SumW + 1;
  localparam int StepW  = $clog2(NumW + 1);
  localparam int MulAW  = PriceW + 1;
  localparam int ProdW  = 2 * PriceW;

  // Configuration registers.
  pop_pkg::pop_mode_e    mode_q;
  logic [PriceW-1:0]     strike_q;
  logic [PriceW-1:0]     second_q;
  logic [DiscW-1:0]      disc_q;

  // Path state.
  logic [PriceW-1:0]     min_q, min_d;
  logic                  crossed_q, crossed_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  // Working registers of the payoff sequencer.
  pop_pkg::pop_state_e   state_q, state_d;
  pop_pkg::pop_mode_e    lmode_q;
  logic [PriceW-1:0]     fin_q;
  logic [PriceW-1:0]     lmin_q;
  logic [MulAW-1:0]      a_q;
  logic [ProdW-1:0]      prod_q;
  logic [NumW-1:0]       quo_q;
  logic [CntW-1:0]       rem_q;
  logic [CntW-1:0]       div_q;
  logic [StepW-1:0]      step_q;
  logic                  cr_q;

  // Output register.
  logic                  out_valid_q;
  logic [PriceW-1:0]     out_pay_q;
  logic                  out_cr_q;

  logic                  smp_acc;
  logic                  last_acc;
  logic                  out_load;
  logic [PriceW-1:0]     x;
  logic                  above;
  logic [PriceW-1:0]     excess;

  // Shared multiplier.
  logic [MulAW-1:0]      mul_a;
  logic [PriceW-1:0]     mul_b;
  logic [ProdW:0]        mul_p;

  // Datapath helpers.
  logic [ProdW-1:0]      fin_w;
  logic [ProdW-1:0]      lb_e;
  logic [ProdW-1:0]      lb_er;
  logic [ProdW-1:0]      rnd;
  logic [CntW:0]         rem_sh;
  logic [CntW:0]         rem_diff;
  logic                  div_ge;
  logic [NumW-1:0]       strike_x;
  logic [NumW-1:0]       cmp_diff;

  assign x        = sample_i.price_sample;
  assign sample_i.ready = (state_q == pop_pkg::StIdle);
  assign smp_acc  = sample_i.valid && sample_i.ready;
  assign last_acc = smp_acc && sample_i.last_sample;
  assign cfg_i.ready = 1'b1;

  assign above  = (x > second_q);
  assign excess = above ? (x - second_q) : '0;

  // ---------------------------------------------------------------------------
  // Configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pop_pkg::PopCall;
      strike_q <= '0;
      second_q <= '0;
      disc_q   <= DiscW'(65536);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (pop_pkg::pop_reg_e'(cfg_i.index))
        pop_pkg::RegPayoffMode:     mode_q   <= pop_pkg::pop_mode_e'(cfg_i.data[1:0]);
        pop_pkg::RegStrikeLevel:    strike_q <= cfg_i.data[PriceW-1:0];
        pop_pkg::RegSecondLevel:    second_q <= cfg_i.data[PriceW-1:0];
        pop_pkg::RegDiscountFactor: disc_q   <= cfg_i.data[DiscW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Path statistics, updated with every accepted sample and cleared on the last one.
  always_comb begin
    min_d     = (x < min_q) ? x : min_q;
    crossed_d = crossed_q | above;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    if (cnt_q < CntW'(MAX_PATH_LEN)) begin
      sum_d = sum_q + SumW'(excess);
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= '1;
      crossed_q <= 1'b0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end else if (last_acc) begin
      min_q     <= '1;
      crossed_q <= 1'b0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end else if (smp_acc) begin
      min_q     <= min_d;
      crossed_q <= crossed_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pop_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      pop_pkg::StIdle: begin
        if (last_acc) begin
          case (mode_q)
            pop_pkg::PopLookback: state_d = pop_pkg::StLbMul;
            pop_pkg::PopCompound: state_d = pop_pkg::StDivPrep;
            default:              state_d = pop_pkg::StDisc;
          endcase
        end
      end
      pop_pkg::StLbMul:   state_d = pop_pkg::StLbSub;
      pop_pkg::StLbSub:   state_d = pop_pkg::StDisc;
      pop_pkg::StDisc:    state_d = pop_pkg::StRound;
      pop_pkg::StDivPrep: state_d = pop_pkg::StDiv;
      pop_pkg::StDiv: begin
        if (step_q == StepW'(NumW - 1)) begin
          state_d = pop_pkg::StCmp;
        end
      end
      pop_pkg::StRound, pop_pkg::StCmp: begin
        // The result goes out once the output register is free.
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = pop_pkg::StIdle;
        end
      end
      default: state_d = pop_pkg::StIdle;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared datapath.
  always_comb begin
    if (state_q == pop_pkg::StLbMul) begin
      mul_a = MulAW'(lmin_q);
      mul_b = second_q;
    end else begin
      mul_a = a_q;
      mul_b = PriceW'(disc_q);
    end
    mul_p = (ProdW + 1)'(mul_a) * (ProdW + 1)'(mul_b);

    // Lookback: final price in Q32.32 less factor times minimum, back to Q16.16.
    fin_w = {16'b0, fin_q, 16'b0};
    lb_e  = (fin_w > prod_q) ? (fin_w - prod_q) : '0;
    lb_er = lb_e + ProdW'(32768);

    rnd = prod_q + ProdW'(32768);

    rem_sh   = {rem_q, quo_q[NumW-1]};
    rem_diff = rem_sh - {1'b0, div_q};
    div_ge   = (rem_sh >= {1'b0, div_q});

    strike_x = NumW'(strike_q);
    cmp_diff = strike_x - quo_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      pop_pkg::StIdle: begin
        if (last_acc) begin
          lmode_q <= mode_q;
          fin_q   <= x;
          lmin_q  <= min_d;
          cr_q    <= crossed_d;
          if ((mode_q == pop_pkg::PopBarrier) && crossed_d) begin
            a_q <= '0;
          end else begin
            a_q <= (x > strike_q) ? MulAW'(x - strike_q) : '0;
          end
          quo_q <= {1'b0, sum_d};
          div_q <= (cnt_d == '0) ? CntW'(1) : cnt_d;
        end
      end
      pop_pkg::StLbMul: prod_q <= mul_p[ProdW-1:0];
      pop_pkg::StLbSub: a_q    <= lb_er[16 +: MulAW];
      pop_pkg::StDisc:  prod_q <= mul_p[ProdW-1:0];
      pop_pkg::StDivPrep: begin
        // Half the divisor first, so that the quotient rounds to nearest.
        quo_q <= quo_q + NumW'(div_q >> 1);
        rem_q <= '0;
      end
      pop_pkg::StDiv: begin
        rem_q <= div_ge ? rem_diff[CntW-1:0] : rem_sh[CntW-1:0];
        quo_q <= {quo_q[NumW-2:0], div_ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == pop_pkg::StDiv) begin
      step_q <= step_q + StepW'(1);
    end else begin
      step_q <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The compound result comes from the compare state, all others from rounding.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pay_q <= (state_q == pop_pkg::StCmp)
                   ? ((strike_x > quo_q) ? cmp_diff[PriceW-1:0] : '0)
                   : ((|rnd[ProdW-1:PriceW+16]) ? '1 : rnd[16 +: PriceW]);
      out_cr_q  <= cr_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.payoff_value    = out_pay_q;
  assign result_o.barrier_crossed = out_cr_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  `POP_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(out_load),
              "Result beat raised without a finished payoff.")
  `POP_ASSERT(a_div_steps, (state_q == pop_pkg::StDiv) |-> (step_q < StepW'(NumW)),
              "Divider ran past its last quotient bit.")
  `POP_ASSERT(a_cnt_cap, cnt_q <= CntW'(MAX_PATH_LEN),
              "Sample count exceeded the path length limit.")
  `POP_ASSERT(a_knock_out, (out_load && (lmode_q == pop_pkg::PopBarrier) && cr_q)
              |=> (out_pay_q == '0),
              "Knocked-out barrier path gave a non-zero payoff.")

endmodule

>>> tb/tb_path_option_payoff.sv
// Self-checking testbench for the path payoff evaluator, with its scoreboard class.
`timescale 1ns / 100ps

typedef struct packed {
  logic [pop_pkg::PriceW-1:0] payoff;
  logic                       crossed;
} payoff_beat_t;

// Tracks the path state and configuration, predicts each payoff beat and checks
// the beats that the block delivers.
class payoff_scoreboard;
  pop_pkg::pop_mode_e         mode;
  logic [pop_pkg::PriceW-1:0] strike;
  logic [pop_pkg::PriceW-1:0] level2;
  logic [pop_pkg::DiscW-1:0]  disc;

  logic [pop_pkg::PriceW-1:0] path_min;
  bit                         path_crossed;
  logic [63:0]                excess;
  int unsigned                count;

  payoff_beat_t               payoff_q[$];
  int unsigned                n_err;
  int unsigned                n_samples;
  int unsigned                n_checked;
  int unsigned                per_mode[4];

  function new();
    mode   = pop_pkg::PopCall;
    strike = '0;
    level2 = '0;
    disc   = 17'd65536;
    n_err  = 0;
    n_samples = 0;
    n_checked = 0;
    foreach (per_mode[m]) per_mode[m] = 0;
    clear_path();
  endfunction

  function void clear_path();
    path_min     = '1;
    path_crossed = 1'b0;
    excess       = '0;
    count        = 0;
  endfunction

  function void write_reg(pop_pkg::pop_reg_e idx, logic [pop_pkg::CfgDataW-1:0] val);
    case (idx)
      pop_pkg::RegPayoffMode:     mode   = pop_pkg::pop_mode_e'(val[1:0]);
      pop_pkg::RegStrikeLevel:    strike = val;
      pop_pkg::RegSecondLevel:    level2 = val;
      pop_pkg::RegDiscountFactor: disc   = val[pop_pkg::DiscW-1:0];
      default: ;
    endcase
  endfunction

  // Applies the discount with round-to-nearest and saturates to 32 bits.
  function logic [31:0] discount(logic [63:0] q);
    logic [63:0] p;
    p = q * {47'd0, disc};
    p = (p + 64'h8000) >> 16;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function logic [31:0] call_value(logic [31:0] fin);
    if (fin > strike) return discount({32'd0, fin - strike});
    return '0;
  endfunction

  function void note_sample(logic [31:0] x, bit last);
    logic [63:0] prod, fin, e, n, mean;
    payoff_beat_t beat;
    n_samples++;
    if (x < path_min) path_min = x;
    if (x > level2) path_crossed = 1'b1;
    if (count < pop_pkg::MaxPathLen) begin
      if (x > level2) excess += {32'd0, x - level2};
      count++;
    end
    if (!last) return;
    case (mode)
      pop_pkg::PopCall: beat.payoff = call_value(x);
      pop_pkg::PopLookback: begin
        prod = {32'd0, level2} * {32'd0, path_min};
        fin  = {16'd0, x, 16'd0};
        e    = (fin > prod) ? fin - prod : 64'd0;
        beat.payoff = discount((e + 64'h8000) >> 16);
      end
      pop_pkg::PopBarrier: beat.payoff = path_crossed ? 32'd0 : call_value(x);
      default: begin
        n    = (count != 0) ? 64'(count) : 64'd1;
        mean = (excess + n / 2) / n;
        beat.payoff = ({32'd0, strike} > mean) ? strike - mean[31:0] : 32'd0;
      end
    endcase
    beat.crossed = path_crossed;
    per_mode[mode]++;
    payoff_q.push_back(beat);
    clear_path();
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    n_err++;
  endtask

  task check_result(logic [31:0] pay, logic crossed);
    payoff_beat_t want;
    if (payoff_q.size() == 0) begin
      report_mismatch($sformatf("payoff beat 0x%08h with no path finished", pay));
      return;
    end
    want = payoff_q.pop_front();
    n_checked++;
    if (pay !== want.payoff)
      report_mismatch($sformatf("payoff 0x%08h, expected 0x%08h (beat %0d)",
                                pay, want.payoff, n_checked));
    if (crossed !== want.crossed)
      report_mismatch($sformatf("barrier_crossed %b, expected %b (beat %0d)",
                                crossed, want.crossed, n_checked));
  endtask
endclass

module tb_path_option_payoff;

  localparam int NumItems   = 1650;
  localparam int CycleLimit = 600000;
  localparam int MaxGap     = 13;

  logic clk;
  logic rst_n;

  pop_smp_if smp ();
  pop_res_if res ();
  pop_cfg_if cfg ();

  path_option_payoff dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (smp),
    .result_o (res),
    .cfg_i    (cfg)
  );

  payoff_scoreboard sb;
  bit               idle_on;
  int unsigned      items_sent;
  int unsigned      n_cfg;
  int unsigned      cycle_cnt;
  bit               long_done;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_sample(input logic [31:0] price, input bit last);
    int gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      smp.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid        = 1'b1;
    smp.price_sample = price;
    smp.last_sample  = last;
    do @(posedge clk); while (!smp.ready);
    sb.note_sample(price, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input pop_pkg::pop_reg_e idx, input logic [31:0] data);
    smp.valid = 1'b0;
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Holds off new samples until every payoff beat is back and the block has settled.
  task automatic wait_idle();
    smp.valid = 1'b0;
    while (sb.payoff_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 32'h0040_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_price();
    int off;
    off = int'($urandom_range(0, 131072)) - 65536;
    case ($urandom_range(0, 5))
      0:       return sb.strike + off;
      1:       return sb.level2 + off;
      2:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      3:       return $urandom_range(0, 32'h0040_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic randomise_config();
    logic [31:0] d;
    d = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
    write_reg(pop_pkg::RegPayoffMode, d);
    if ($urandom_range(0, 1) != 0) write_reg(pop_pkg::RegStrikeLevel, pick_level());
    if ($urandom_range(0, 1) != 0) begin
      if (sb.mode == pop_pkg::PopLookback && $urandom_range(0, 2) != 0)
        d = $urandom_range(0, 32'h0002_0000);
      else
        d = pick_level();
      write_reg(pop_pkg::RegSecondLevel, d);
    end
    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 4))
        0:       d = 32'd0;
        1:       d = 32'd131071;
        2:       d = 32'd65536;
        3:       d = $urandom;
        default: d = $urandom_range(0, 131071);
      endcase
      write_reg(pop_pkg::RegDiscountFactor, d);
    end
  endtask

  // Payoff sink: with idle gaps on, ready drops for a random gap, possibly empty, before each beat.
  initial begin
    int gap;
    res.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, MaxGap) : 0;
      res.ready = 1'b0;
      repeat (gap) @(negedge clk);
      res.ready = 1'b1;
      do @(posedge clk); while (!res.valid);
      sb.check_result(res.payoff_value, res.barrier_crossed);
      @(negedge clk);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d payoff beats outstanding",
             cycle_cnt, sb.payoff_q.size());
    $display("[path_option_payoff] ERROR");
    $finish;
  end

  initial begin
    int len;
    sb         = new();
    items_sent = 0;
    n_cfg      = 0;
    long_done  = 1'b0;
    idle_on    = 1'b1;
    rst_n            = 1'b0;
    smp.valid        = 1'b0;
    smp.price_sample = '0;
    smp.last_sample  = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = pop_pkg::RegPayoffMode;
    cfg.data         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Reset settings: a call with zero strike and unit discount.
    send_sample(32'd0, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);

    // Call with the largest discount, up to saturation.
    wait_idle();
    write_reg(pop_pkg::RegPayoffMode, 32'(pop_pkg::PopCall));
    write_reg(pop_pkg::RegStrikeLevel, 32'h0001_0000);
    write_reg(pop_pkg::RegSecondLevel, 32'hFFFF_FFFF);
    write_reg(pop_pkg::RegDiscountFactor, 32'd131071);
    send_sample(32'h0005_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);

    // Lookback at half the minimum, then a factor so large that it floors at zero.
    wait_idle();
    write_reg(pop_pkg::RegPayoffMode, 32'(pop_pkg::PopLookback));
    write_reg(pop_pkg::RegSecondLevel, 32'h0000_8000);
    write_reg(pop_pkg::RegDiscountFactor, 32'd65536);
    send_sample(32'h000A_0000, 1'b0);
    send_sample(32'h0004_0000, 1'b0);
    send_sample(32'h0008_0000, 1'b1);
    wait_idle();
    write_reg(pop_pkg::RegSecondLevel, 32'hFFFF_FFFF);
    send_sample(32'h0100_0000, 1'b1);

    // Knock-out barrier at 16.0: one crossed path, one clean path.
    wait_idle();
    write_reg(pop_pkg::RegPayoffMode, 32'(pop_pkg::PopBarrier));
    write_reg(pop_pkg::RegSecondLevel, 32'h0010_0000);
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'h0014_0000, 1'b0);
    send_sample(32'h0003_0000, 1'b1);
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'h0003_0000, 1'b1);

    // Compound average of the excesses over 10.0 against a strike of 100.0.
    wait_idle();
    write_reg(pop_pkg::RegPayoffMode, 32'(pop_pkg::PopCompound));
    write_reg(pop_pkg::RegStrikeLevel, 32'h0064_0000);
    write_reg(pop_pkg::RegSecondLevel, 32'h000A_0000);
    send_sample(32'h000C_0000, 1'b0);
    send_sample(32'h000F_0000, 1'b0);
    send_sample(32'h0008_0000, 1'b1);

    // Zero discount wipes out a call payoff.
    wait_idle();
    write_reg(pop_pkg::RegPayoffMode, 32'(pop_pkg::PopCall));
    write_reg(pop_pkg::RegDiscountFactor, 32'd0);
    send_sample(32'h00FF_0000, 1'b1);

    items_sent = 0;
    while (items_sent < NumItems) begin
      if (!long_done && items_sent >= 500) begin
        // One path longer than the limit, so the count and excess stop growing.
        wait_idle();
        write_reg(pop_pkg::RegPayoffMode, 32'(pop_pkg::PopCompound));
        write_reg(pop_pkg::RegSecondLevel, $urandom_range(0, 32'h0020_0000));
        len = pop_pkg::MaxPathLen + $urandom_range(1, 8);
        long_done = 1'b1;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          wait_idle();
          randomise_config();
        end else if ($urandom_range(0, 9) == 0) begin
          wait_idle();
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) send_sample(pick_price(), k == len - 1);
    end

    idle_on = 1'b1;
    wait_idle();
    repeat (60) @(negedge clk);

    $display("covered %0d samples, %0d payoffs (call %0d, lb %0d, barrier %0d, cmpd %0d)",
             sb.n_samples, sb.n_checked, sb.per_mode[pop_pkg::PopCall],
             sb.per_mode[pop_pkg::PopLookback], sb.per_mode[pop_pkg::PopBarrier],
             sb.per_mode[pop_pkg::PopCompound]);
    $display("%0d register writes, one path past the length limit, %0d mismatches",
             n_cfg, sb.n_err);
    if (sb.n_err == 0) begin
      $display("[path_option_payoff] OK");
    end else begin
      $display("[path_option_payoff] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/pop_pkg.sv
hdl/pop_intf.sv
hdl/path_option_payoff.sv
tb/tb_path_option_payoff.sv
